FILE: rtl/core/ils_pkg.sv
`default_nettype none

package ils_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned LEN_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // read_value for errors and for every command other than read
  localparam logic [WORD_W-1:0] NO_READ = '1;

  // broadcast to every cell; edit commands are already qualified
  typedef struct packed {
    logic              append;
    logic              write;
    logic              remove;
    logic              lane_load;
    logic              lane_shift;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/ils_req_if.sv
`default_nettype none

interface ils_req_if;
  logic                                valid;
  logic                                ready;
  logic [ils_pkg::CMD_W-1:0]           command;
  logic [ils_pkg::IDX_W-1:0]           index;
  logic signed [ils_pkg::WORD_W-1:0]   value;

  modport source (output valid, command, index, value, input ready);
  modport sink   (input valid, command, index, value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ils_rsp_if.sv
`default_nettype none

interface ils_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ils_pkg::WORD_W-1:0]   read_value;
  logic [ils_pkg::ST_W-1:0]            status;
  logic [ils_pkg::LEN_W-1:0]           list_length;

  modport source (output valid, read_value, status, list_length, input ready);
  modport sink   (input valid, read_value, status, list_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ils_cell.sv
`default_nettype none

module ils_cell #(
  parameter int unsigned POS = 0,
  parameter int unsigned CW  = 9
) (
  input  wire logic                          clk_i,
  input  wire ils_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [CW-1:0]                 count_i,
  input  wire logic [ils_pkg::WORD_W-1:0]    upper_entry_i,
  input  wire logic [ils_pkg::WORD_W-1:0]    upper_lane_i,
  output logic      [ils_pkg::WORD_W-1:0]    entry_o,
  output logic      [ils_pkg::WORD_W-1:0]    lane_o
);

  localparam int unsigned PW = (CW > ils_pkg::IDX_W) ? CW : ils_pkg::IDX_W;

  logic [ils_pkg::WORD_W-1:0] entry_q;
  logic [ils_pkg::WORD_W-1:0] lane_q;
  logic                       wr_hit;
  logic                       rm_hit;

  always_comb begin
    wr_hit = (ctrl_i.append && (count_i == CW'(POS)))
          || (ctrl_i.write && (PW'(ctrl_i.index) == PW'(POS)));
    // every cell at or above the removed one takes its upper neighbor
    rm_hit = ctrl_i.remove && (PW'(ctrl_i.index) <= PW'(POS));
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      entry_q <= ctrl_i.value;
    end else if (rm_hit) begin
      entry_q <= upper_entry_i;
    end
  end

  // read lane: snapshot of the list that moves down one cell per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.lane_load) begin
      lane_q <= entry_q;
    end else if (ctrl_i.lane_shift) begin
      lane_q <= upper_lane_i;
    end
  end

  assign entry_o = entry_q;
  assign lane_o  = lane_q;

endmodule

`default_nettype wire

FILE: rtl/core/indexed_list_store.sv
// Ordered list of up to CAPACITY signed 32-bit words, one word per cell of a
// chain. Each request is append, read, write or remove, and gives exactly one
// response with a status (ok, index out of bounds, full) and the list length
// after the request. For append, write, remove and any out-of-bounds request
// the cells update in parallel, and a remove moves every later word down one
// cell at once. A read at index k copies the list into a read lane that moves
// down one cell per cycle until word k reaches cell 0; the response is loaded
// when the output register is free. Requests are taken one at a time; a
// response waits in an output register, and the next request is taken while
// it is being taken. Stored words come up undefined after reset; only words
// below the length are ever read.
`default_nettype none

module indexed_list_store #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ils_req_if.sink    req_i,
  ils_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > ils_pkg::IDX_W) ? CW : ils_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SHIFT = 2'b10
  } fsm_e;

  fsm_e                        state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic [ils_pkg::IDX_W-1:0]   shift_cnt_q, shift_cnt_d;

  logic                        rsp_valid_q, rsp_valid_d;
  logic [ils_pkg::WORD_W-1:0]  rsp_value_q, rsp_value_d;
  logic [ils_pkg::ST_W-1:0]    rsp_status_q, rsp_status_d;
  logic [ils_pkg::LEN_W-1:0]   rsp_len_q, rsp_len_d;

  logic                        accept;
  logic                        rsp_free;
  logic                        in_range;
  logic                        full;
  logic                        rsp_load;
  ils_pkg::cmd_e               cmd;
  ils_pkg::cell_ctrl_t         ctrl;

  logic [ils_pkg::WORD_W-1:0]  entry_w [CAPACITY];
  logic [ils_pkg::WORD_W-1:0]  lane_w  [CAPACITY];

  assign cmd      = ils_pkg::cmd_e'(req_i.command);
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign in_range = PW'(req_i.index) < PW'(count_q);
  assign full     = count_q == CW'(CAPACITY);

  assign req_i.ready = (state_q == S_IDLE) && rsp_free;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    shift_cnt_d  = shift_cnt_q;
    rsp_load     = 1'b0;
    rsp_value_d  = ils_pkg::NO_READ;
    rsp_status_d = ils_pkg::ST_OK;

    ctrl            = '0;
    ctrl.index      = req_i.index;
    ctrl.value      = req_i.value;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            ils_pkg::CMD_APPEND: begin
              rsp_load = 1'b1;
              if (full) begin
                rsp_status_d = ils_pkg::ST_FULL;
              end else begin
                ctrl.append = 1'b1;
                count_d     = count_q + CW'(1);
              end
            end
            ils_pkg::CMD_READ: begin
              if (in_range) begin
                ctrl.lane_load = 1'b1;
                shift_cnt_d    = req_i.index;
                state_d        = S_SHIFT;
              end else begin
                rsp_load     = 1'b1;
                rsp_status_d = ils_pkg::ST_RANGE;
              end
            end
            ils_pkg::CMD_WRITE: begin
              rsp_load = 1'b1;
              if (in_range) begin
                ctrl.write = 1'b1;
              end else begin
                rsp_status_d = ils_pkg::ST_RANGE;
              end
            end
            ils_pkg::CMD_REMOVE: begin
              rsp_load = 1'b1;
              if (in_range) begin
                ctrl.remove = 1'b1;
                count_d     = count_q - CW'(1);
              end else begin
                rsp_status_d = ils_pkg::ST_RANGE;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (shift_cnt_q != '0) begin
          ctrl.lane_shift = 1'b1;
          shift_cnt_d     = shift_cnt_q - ils_pkg::IDX_W'(1);
        end else if (rsp_free) begin
          // requested word has reached the bottom cell
          rsp_load    = 1'b1;
          rsp_value_d = lane_w[0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_len_d = ils_pkg::LEN_W'(count_d);

    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ils_pkg::WORD_W-1:0] upper_entry;
    logic [ils_pkg::WORD_W-1:0] upper_lane;

    if (g == CAPACITY - 1) begin : g_top
      assign upper_entry = '0;
      assign upper_lane  = '0;
    end else begin : g_mid
      assign upper_entry = entry_w[g+1];
      assign upper_lane  = lane_w[g+1];
    end

    ils_cell #(
      .POS (g),
      .CW  (CW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .upper_entry_i (upper_entry),
      .upper_lane_i  (upper_lane),
      .entry_o       (entry_w[g]),
      .lane_o        (lane_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_cnt_q <= shift_cnt_d;
    if (rsp_load) begin
      rsp_value_q  <= rsp_value_d;
      rsp_status_q <= rsp_status_d;
      rsp_len_q    <= rsp_len_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_value  = rsp_value_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.list_length = rsp_len_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_no_req_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> !req_i.ready)
    else $error("request taken during read");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == ils_pkg::CMD_APPEND && !full |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == ils_pkg::CMD_REMOVE && in_range
    |=> count_q == $past(count_q) - CW'(1))
    else $error("remove did not shrink the list");

  a_shift_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT && shift_cnt_q != '0 |=> state_q == S_SHIFT)
    else $error("read left before word reached cell 0");
`endif

endmodule

`default_nettype wire

FILE: tb/ils_list_checker.sv
`default_nettype none

module ils_list_checker
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ils_req_if        req_i,
  ils_rsp_if        rsp_i,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct {
    logic signed [WORD_W-1:0] read_value;
    status_e                  status;
    logic [LEN_W-1:0]         list_length;
  } list_rsp_t;

  logic signed [WORD_W-1:0] words [CAPACITY];
  int unsigned              stored;
  list_rsp_t                expected_q [$];
  int                       fails;

  // apply one request to the list copy and queue the response it must give
  task automatic apply_request(input cmd_e cmd, input logic [IDX_W-1:0] idx,
                               input logic signed [WORD_W-1:0] val);
    list_rsp_t want;
    int unsigned i;
    want.read_value = NO_READ;
    want.status     = ST_OK;
    if (cmd == CMD_APPEND) begin
      if (stored >= CAPACITY) begin
        want.status = ST_FULL;
      end else begin
        words[stored] = val;
        stored++;
      end
    end else if (idx >= stored) begin
      want.status = ST_RANGE;
    end else begin
      case (cmd)
        CMD_READ: want.read_value = words[idx];
        CMD_WRITE: words[idx] = val;
        default: begin
          // close the gap, later words move down one place
          for (i = idx; i + 1 < stored; i++) words[i] = words[i + 1];
          stored--;
        end
      endcase
    end
    want.list_length = stored[LEN_W-1:0];
    expected_q.push_back(want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_rsp_t want;
    if (!rst_ni) begin
      expected_q.delete();
      stored = 0;
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (expected_q.size() == 0) begin
          $display("%0t: response with no request waiting: read_value %0d status %0d length %0d",
                   $time, rsp_i.read_value, rsp_i.status, rsp_i.list_length);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                     rsp_i.read_value);
            fails++;
          end
          if (rsp_i.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     rsp_i.status);
            fails++;
          end
          if (rsp_i.list_length !== want.list_length) begin
            $display("%0t: list_length expected %0d actual %0d", $time, want.list_length,
                     rsp_i.list_length);
            fails++;
          end
        end
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        apply_request(cmd_e'(req_i.command), req_i.index, req_i.value);
      end
      fail_count_o <= fails;
      pending_o <= expected_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
  import ils_pkg::*;

  localparam int unsigned CAP          = 256;
  localparam int unsigned RAND_ITEMS   = 1130;
  localparam int unsigned LONG_HOLD    = 500;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  typedef enum int unsigned {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending;
  int unsigned responses_seen;
  int unsigned list_len;
  int unsigned quiet_left;
  logic        long_hold_done;

  ils_req_if req ();
  ils_rsp_if rsp ();

  indexed_list_store #(.CAPACITY(CAP)) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  ils_list_checker #(.CAPACITY(CAP)) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      responses_seen <= 0;
    end else if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      responses_seen <= responses_seen + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80 && list_len > 0) return IDX_W'($urandom_range(0, list_len - 1));
    if (r < 88) return (list_len > 0) ? IDX_W'(list_len - 1) : '0;
    if (r < 94) return IDX_W'(list_len);
    return IDX_W'($urandom_range(0, 511));
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic cmd_e pick_cmd(input mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 70) return CMD_APPEND;
        if (r < 82) return CMD_READ;
        if (r < 92) return CMD_WRITE;
        return CMD_REMOVE;
      end
      MIX_SHRINK: begin
        if (r < 10) return CMD_APPEND;
        if (r < 40) return CMD_READ;
        if (r < 60) return CMD_WRITE;
        return CMD_REMOVE;
      end
      default: begin
        if (r < 30) return CMD_APPEND;
        if (r < 60) return CMD_READ;
        if (r < 80) return CMD_WRITE;
        return CMD_REMOVE;
      end
    endcase
  endfunction

  task automatic issue_request(input cmd_e cmd, input logic [IDX_W-1:0] idx,
                               input logic signed [WORD_W-1:0] val);
    int unsigned gap;
    if (quiet_left != 0) begin
      quiet_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 29) == 0) quiet_left = 60;
    end
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.index   <= idx;
    req.value   <= val;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    // rough length, only used to aim indexes
    if (cmd == CMD_APPEND && list_len < CAP) list_len++;
    else if (cmd == CMD_REMOVE && idx < list_len) list_len--;
  endtask

  task automatic wait_all_responses();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // response side: random stalls, one long hold-off to back up the block
  initial begin : rsp_side
    int unsigned run;
    int unsigned gap;
    long_hold_done = 1'b0;
    rsp.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!long_hold_done && responses_seen >= 200) begin
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end
      rsp.ready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : req_side
    mix_e        mix;
    int unsigned phase_left;
    int unsigned n;
    rst_n          <= 1'b0;
    req.valid      <= 1'b0;
    req.command    <= CMD_APPEND;
    req.index      <= '0;
    req.value      <= '0;
    list_len       = 0;
    quiet_left     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, extremes of the word, bounds of the index
    issue_request(CMD_READ, 0, 0);
    issue_request(CMD_REMOVE, 0, 0);
    issue_request(CMD_WRITE, 0, 32'sd77);
    issue_request(CMD_APPEND, 9'd511, 32'h7FFF_FFFF);
    issue_request(CMD_APPEND, 0, 32'h8000_0000);
    issue_request(CMD_APPEND, 0, '1);
    issue_request(CMD_APPEND, 0, '0);
    issue_request(CMD_READ, 0, 0);
    issue_request(CMD_READ, 1, 0);
    issue_request(CMD_READ, 2, 0);
    issue_request(CMD_READ, 3, '1);
    issue_request(CMD_READ, 4, 0);
    issue_request(CMD_READ, 9'd511, 0);
    issue_request(CMD_WRITE, 2, 32'h5A5A_5A5A);
    issue_request(CMD_READ, 2, 0);
    issue_request(CMD_REMOVE, 0, 0);
    issue_request(CMD_READ, 0, 0);
    issue_request(CMD_REMOVE, 2, 0);
    issue_request(CMD_READ, 9'd256, 0);
    issue_request(CMD_WRITE, 9'd300, 32'sd5);
    issue_request(CMD_REMOVE, 5, 0);
    issue_request(CMD_READ, 1, 0);

    // first phase mostly appends to grow the list, then the mix wanders
    mix = MIX_GROW;
    phase_left = 340;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        mix = mix_e'($urandom_range(0, 2));
        phase_left = $urandom_range(80, 200);
      end
      phase_left--;
      if (n == 500) wait_all_responses();
      issue_request(pick_cmd(mix), pick_index(), pick_value());
    end

    wait_all_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: indexed_list_store.f
rtl/core/ils_pkg.sv
rtl/core/ils_req_if.sv
rtl/core/ils_rsp_if.sv
rtl/core/ils_cell.sv
rtl/core/indexed_list_store.sv
tb/ils_list_checker.sv
tb/tb.sv
